FILE: design/rltnb_pkg.sv
// Package for the RTP loss tracker and NACK builder.
// Payload structs, codes, command/status structs and serial-number compares.
// No dependencies.
package rltnb_pkg;

  localparam logic [15:0] SEQ_HALF = 16'h8000;
  localparam logic [9:0]  FOLLOW_MAX = 10'd1023;

  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  localparam logic [1:0] STATUS_ENTRY = 2'd0;
  localparam logic [1:0] STATUS_NONE  = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic        operation;
    logic [15:0] seq_num;
    logic [31:0] packet_ssrc;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] run_start;
    logic [9:0]  run_follow;
    logic [31:0] report_ssrc;
    logic [4:0]  entry_total;
    logic        last_entry;
  } out_t;

  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_ENTRY,
    OUT_EMPTY,
    OUT_FULL
  } out_sel_e;

  typedef struct packed {
    logic     latch;
    logic     first_pkt;
    logic     clr_init;
    logic     clr_step;
    logic     upd_newest;
    logic     old_hit;
    logic     adv_rd;
    logic     adv_inc;
    logic     mark;
    logic     init_step;
    logic     rep_init;
    logic     rep_rd;
    logic     rep_ev;
    logic     emit_rd;
    out_sel_e out_sel;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic first;
    logic gt;
    logic lt;
    logic hit_next;
    logic clr_done;
    logic gap_big;
    logic adv_in;
    logic rdata;
    logic rep_in;
    logic ev_full;
    logic ecnt_zero;
    logic emit_last;
    logic out_free;
    logic init_last;
  } st_t;

  // a before b in 16-bit serial order
  function automatic logic seq_lt(logic [15:0] a, logic [15:0] b);
    logic [15:0] d;
    d = b - a;
    return (d != 16'd0) && (d < SEQ_HALF);
  endfunction

  function automatic logic seq_le(logic [15:0] a, logic [15:0] b);
    logic [15:0] d;
    d = b - a;
    return d < SEQ_HALF;
  endfunction

  function automatic logic seq_gt(logic [15:0] a, logic [15:0] b);
    logic [15:0] d;
    d = a - b;
    return (d != 16'd0) && (d <= SEQ_HALF);
  endfunction

endpackage

FILE: design/rltnb_ctrl.sv
// Controller state machine for the RTP loss tracker.
// Sequences packet updates, bitmap walks and report output. Uses rltnb_pkg.
module rltnb_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  rltnb_pkg::st_t  st_i,
  output rltnb_pkg::cmd_t cmd_o
);

  localparam logic [3:0] S_INIT      = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_DISP      = 4'd2;
  localparam logic [3:0] S_CLR       = 4'd3;
  localparam logic [3:0] S_ADV_RD    = 4'd4;
  localparam logic [3:0] S_ADV_EV    = 4'd5;
  localparam logic [3:0] S_MARK      = 4'd6;
  localparam logic [3:0] S_REP_RD    = 4'd7;
  localparam logic [3:0] S_REP_EV    = 4'd8;
  localparam logic [3:0] S_REP_END   = 4'd9;
  localparam logic [3:0] S_EMPTY_OUT = 4'd10;
  localparam logic [3:0] S_FULL_OUT  = 4'd11;
  localparam logic [3:0] S_EMIT_RD   = 4'd12;
  localparam logic [3:0] S_EMIT_LD   = 4'd13;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.out_sel = rltnb_pkg::OUT_NONE;
    case (state_q)
      S_INIT: begin
        cmd_o.init_step = 1'b1;
        if (st_i.init_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        if (st_i.op == rltnb_pkg::OP_REPORT) begin
          cmd_o.rep_init = 1'b1;
          state_d = S_REP_RD;
        end else if (st_i.first) begin
          cmd_o.first_pkt = 1'b1;
          cmd_o.mark = 1'b1;
          state_d = S_IDLE;
        end else if (st_i.gt) begin
          cmd_o.clr_init = 1'b1;
          state_d = S_CLR;
        end else if (st_i.lt && st_i.hit_next) begin
          cmd_o.old_hit = 1'b1;
          state_d = S_ADV_RD;
        end else begin
          cmd_o.mark = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_CLR: begin
        if (st_i.clr_done) begin
          cmd_o.upd_newest = 1'b1;
          if (st_i.gap_big) begin
            state_d = S_ADV_RD;
          end else begin
            cmd_o.mark = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          cmd_o.clr_step = 1'b1;
        end
      end
      S_ADV_RD: begin
        if (st_i.adv_in) begin
          cmd_o.adv_rd = 1'b1;
          state_d = S_ADV_EV;
        end else begin
          state_d = S_MARK;
        end
      end
      S_ADV_EV: begin
        if (st_i.rdata) begin
          cmd_o.adv_inc = 1'b1;
          state_d = S_ADV_RD;
        end else begin
          state_d = S_MARK;
        end
      end
      S_MARK: begin
        cmd_o.mark = 1'b1;
        state_d = S_IDLE;
      end
      S_REP_RD: begin
        if (st_i.rep_in) begin
          cmd_o.rep_rd = 1'b1;
          state_d = S_REP_EV;
        end else begin
          state_d = S_REP_END;
        end
      end
      S_REP_EV: begin
        cmd_o.rep_ev = 1'b1;
        state_d = st_i.ev_full ? S_FULL_OUT : S_REP_RD;
      end
      S_REP_END: begin
        state_d = st_i.ecnt_zero ? S_EMPTY_OUT : S_EMIT_RD;
      end
      S_EMPTY_OUT: begin
        if (st_i.out_free) begin
          cmd_o.out_sel = rltnb_pkg::OUT_EMPTY;
          state_d = S_IDLE;
        end
      end
      S_FULL_OUT: begin
        if (st_i.out_free) begin
          cmd_o.out_sel = rltnb_pkg::OUT_FULL;
          state_d = S_IDLE;
        end
      end
      S_EMIT_RD: begin
        if (st_i.out_free) begin
          cmd_o.emit_rd = 1'b1;
          state_d = S_EMIT_LD;
        end
      end
      S_EMIT_LD: begin
        cmd_o.out_sel = rltnb_pkg::OUT_ENTRY;
        state_d = st_i.emit_last ? S_IDLE : S_EMIT_RD;
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

endmodule

FILE: design/rltnb_dp.sv
// Datapath for the RTP loss tracker: pointers, received bitmap, entry buffer
// and output register. Driven by rltnb_ctrl commands. Uses rltnb_pkg.
module rltnb_dp #(
  parameter int WINDOW_BITS = 1024,
  parameter int MAX_ENTRIES = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rltnb_pkg::in_t  in_data_i,
  input  logic            cfg_valid_i,
  input  logic [9:0]      cfg_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output rltnb_pkg::out_t out_data_o,
  input  rltnb_pkg::cmd_t cmd_i,
  output rltnb_pkg::st_t  st_o
);

  localparam int IW = $clog2(WINDOW_BITS);
  localparam int EW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [15:0] WinSeq = 16'(WINDOW_BITS);
  localparam logic [IW-1:0] IdxLast = IW'(WINDOW_BITS - 1);
  localparam logic [CW-1:0] CntLast = CW'(MAX_ENTRIES - 1);

  logic [9:0]  skip_q;
  logic [31:0] stream_q;
  logic [15:0] contig_q, newest_q, end_q;
  rltnb_pkg::in_t item_q;
  logic [15:0] iter_q, cnt_q, start_q, miss_q;
  logic [CW-1:0] ecnt_q;
  logic [EW-1:0] k_q;
  logic          out_valid_q;
  rltnb_pkg::out_t out_q;

  logic          map_mem [WINDOW_BITS];
  logic          map_rd_q;
  logic [31:0]   buf_mem [MAX_ENTRIES];
  logic [31:0]   buf_rd_q;

  logic [15:0] gap, dist_m1, clr_cnt, contig_p1, iter_p1, miss_m1;
  logic [9:0]  follow;
  logic        got, ev_write;
  logic        map_we, map_wd;
  logic [IW-1:0] map_wa, map_ra;
  logic [31:0] ecnt_ext;

  assign gap       = item_q.seq_num - contig_q;
  assign dist_m1   = item_q.seq_num - newest_q - 16'd1;
  assign clr_cnt   = (dist_m1 > WinSeq) ? WinSeq : dist_m1;
  assign contig_p1 = contig_q + 16'd1;
  assign iter_p1   = iter_q + 16'd1;
  assign miss_m1   = miss_q - 16'd1;
  assign follow    = (miss_m1 > 16'(rltnb_pkg::FOLLOW_MAX)) ? rltnb_pkg::FOLLOW_MAX
                                                            : miss_m1[9:0];
  assign got       = map_rd_q || (iter_q[IW-1:0] == end_q[IW-1:0]);
  assign ev_write  = cmd_i.rep_ev && got && (miss_q != 16'd0);
  assign ecnt_ext  = 32'(ecnt_q);

  always_comb begin
    map_we = 1'b0;
    map_wd = 1'b0;
    map_wa = iter_q[IW-1:0];
    if (cmd_i.init_step || cmd_i.clr_step) begin
      map_we = 1'b1;
    end else if (cmd_i.mark) begin
      map_we = 1'b1;
      map_wd = 1'b1;
      map_wa = item_q.seq_num[IW-1:0];
    end
    map_ra = cmd_i.adv_rd ? contig_p1[IW-1:0] : iter_q[IW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    if (cmd_i.adv_rd || cmd_i.rep_rd) map_rd_q <= map_mem[map_ra];
    if (ev_write) buf_mem[ecnt_q[EW-1:0]] <= {start_q, 6'd0, follow};
    if (cmd_i.emit_rd) buf_rd_q <= buf_mem[k_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q      <= '0;
      stream_q    <= '0;
      contig_q    <= '0;
      newest_q    <= '0;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) skip_q <= cfg_data_i;
      if (cmd_i.init_step) iter_q <= iter_p1;
      if (cmd_i.first_pkt) begin
        stream_q <= item_q.packet_ssrc;
        contig_q <= item_q.seq_num;
        newest_q <= item_q.seq_num;
      end
      if (cmd_i.clr_init) begin
        iter_q <= newest_q + 16'd1;
      end
      if (cmd_i.clr_step) begin
        iter_q <= iter_p1;
      end
      if (cmd_i.upd_newest) begin
        newest_q <= item_q.seq_num;
        if (gap > WinSeq) begin
          contig_q <= item_q.seq_num - WinSeq;
        end else if (gap == 16'd1) begin
          contig_q <= item_q.seq_num;
        end
      end
      if (cmd_i.old_hit) contig_q <= item_q.seq_num;
      if (cmd_i.adv_inc) contig_q <= contig_p1;
      if (cmd_i.rep_init) iter_q <= contig_p1;
      if (cmd_i.rep_ev) iter_q <= iter_p1;
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (cmd_i.out_sel != rltnb_pkg::OUT_NONE) out_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) item_q <= in_data_i;
    if (cmd_i.clr_init) cnt_q <= clr_cnt;
    if (cmd_i.clr_step) cnt_q <= cnt_q - 16'd1;
    if (cmd_i.rep_init) begin
      start_q <= contig_p1;
      miss_q  <= '0;
      ecnt_q  <= '0;
      k_q     <= '0;
      end_q   <= newest_q - {6'd0, skip_q};
    end
    if (cmd_i.rep_ev) begin
      if (!got) begin
        miss_q <= miss_q + 16'd1;
      end else begin
        miss_q  <= '0;
        start_q <= iter_p1;
        if (ev_write) ecnt_q <= ecnt_q + CW'(1);
      end
    end
    if (cmd_i.out_sel == rltnb_pkg::OUT_ENTRY) k_q <= k_q + EW'(1);
    case (cmd_i.out_sel)
      rltnb_pkg::OUT_ENTRY: begin
        out_q.status      <= rltnb_pkg::STATUS_ENTRY;
        out_q.run_start   <= buf_rd_q[31:16];
        out_q.run_follow  <= buf_rd_q[9:0];
        out_q.report_ssrc <= stream_q;
        out_q.entry_total <= ecnt_ext[4:0];
        out_q.last_entry  <= st_o.emit_last;
      end
      rltnb_pkg::OUT_EMPTY, rltnb_pkg::OUT_FULL: begin
        out_q.status      <= (cmd_i.out_sel == rltnb_pkg::OUT_FULL) ?
                             rltnb_pkg::STATUS_FULL : rltnb_pkg::STATUS_NONE;
        out_q.run_start   <= '0;
        out_q.run_follow  <= '0;
        out_q.report_ssrc <= stream_q;
        out_q.entry_total <= '0;
        out_q.last_entry  <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    st_o.op        = item_q.operation;
    st_o.first     = (stream_q == 32'd0);
    st_o.gt        = rltnb_pkg::seq_gt(item_q.seq_num, newest_q);
    st_o.lt        = rltnb_pkg::seq_lt(item_q.seq_num, newest_q);
    st_o.hit_next  = (item_q.seq_num == contig_p1);
    st_o.clr_done  = (cnt_q == 16'd0);
    st_o.gap_big   = (gap > WinSeq);
    st_o.adv_in    = rltnb_pkg::seq_le(contig_p1, newest_q);
    st_o.rdata     = map_rd_q;
    st_o.rep_in    = rltnb_pkg::seq_le(iter_q, end_q);
    st_o.ev_full   = ev_write && (ecnt_q == CntLast);
    st_o.ecnt_zero = (ecnt_q == '0);
    st_o.emit_last = ((CW'(k_q) + CW'(1)) == ecnt_q);
    st_o.out_free  = !out_valid_q;
    st_o.init_last = (iter_q[IW-1:0] == IdxLast);
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_sel != rltnb_pkg::OUT_NONE) |-> !out_valid_q)
    else $error("output loaded while occupied");
  a_buf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_write |-> (ecnt_q < CW'(MAX_ENTRIES)))
    else $error("entry buffer overrun");
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.status != rltnb_pkg::STATUS_ENTRY)) |-> out_q.last_entry)
    else $error("status result without last flag");

endmodule

FILE: design/rtp_loss_tracker_nack_builder.sv
// RTP loss tracker and generic NACK builder, top level.
// Packet item: handled in order; a forward jump first clears the skipped numbers in the
// bitmap (at most WINDOW_BITS bits), and a contiguous rescan reads, then tests, each advanced number.
// Report: each scanned number is read and evaluated, then each result waits for a free output.
// After reset a clearing pass over all WINDOW_BITS bitmap bits runs with input stalled.
module rtp_loss_tracker_nack_builder #(
  parameter int WINDOW_BITS = 1024,
  parameter int MAX_ENTRIES = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  rltnb_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output rltnb_pkg::out_t out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [9:0]      cfg_data_i
);

  rltnb_pkg::cmd_t cmd;
  rltnb_pkg::st_t  st;

  assign cfg_ready_o = 1'b1;

  rltnb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  rltnb_dp #(
    .WINDOW_BITS (WINDOW_BITS),
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .st_o        (st)
  );

endmodule

FILE: sim/rtp_loss_tracker_nack_builder_tb.sv
// Testbench for rtp_loss_tracker_nack_builder: directed and random packet/report traffic,
// checked against an in-bench loss map predictor. Depends on rltnb_pkg and the RTL top.
module rtp_loss_tracker_nack_builder_tb;

  localparam int WIN = 1024;
  localparam int MAX_ENT = 32;
  localparam int SETTLE = 4000;
  localparam int LIMIT = 2000000;

  logic clk_i, rst_ni;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  rltnb_pkg::in_t  in_data;
  rltnb_pkg::out_t out_data;
  logic [9:0] cfg_data;

  rtp_loss_tracker_nack_builder dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  // predictor state
  logic [31:0] trk_ssrc;
  logic [15:0] trk_contig, trk_newest;
  logic [9:0]  trk_skip;
  logic        rx_map [WIN];
  rltnb_pkg::out_t expected_results [$];

  int errors = 0;
  int cycles = 0;
  int stall_pct = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver stall pattern: changes character every so often, including stall-free stretches
  initial begin
    int span;
    out_stall = 1'b0;
    forever begin
      span = $urandom_range(20, 200);
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 20;
        2: stall_pct = 50;
        default: stall_pct = 85;
      endcase
      repeat (span) begin
        @(negedge clk_i);
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  function automatic int seq_order(logic [15:0] a, logic [15:0] b);
    logic [15:0] d;
    d = b - a;
    if (d == 16'd0) return 0;
    if (d < 16'h8000) return -1;
    return 1;
  endfunction

  function automatic int widx(logic [15:0] s);
    return int'(s) % WIN;
  endfunction

  task automatic rescan_contig();
    logic [15:0] s;
    s = trk_contig + 16'd1;
    while (seq_order(s, trk_newest) <= 0 && rx_map[widx(s)]) begin
      trk_contig = s;
      s = s + 16'd1;
    end
  endtask

  task automatic track_packet(logic [15:0] seq, logic [31:0] ssrc);
    int c;
    logic [15:0] s, gap;
    if (trk_ssrc == 32'd0) begin
      trk_ssrc = ssrc;
      trk_contig = seq;
      trk_newest = seq;
      rx_map[widx(seq)] = 1'b1;
      return;
    end
    c = seq_order(seq, trk_newest);
    if (c > 0) begin
      s = trk_newest + 16'd1;
      while (seq_order(s, seq) < 0) begin
        rx_map[widx(s)] = 1'b0;
        s = s + 16'd1;
      end
      trk_newest = seq;
      gap = seq - trk_contig;
      if (int'(gap) > WIN) begin
        trk_contig = seq - 16'(WIN);
        rescan_contig();
      end else if (gap == 16'd1) begin
        trk_contig = seq;
      end
    end else if (c < 0 && seq == trk_contig + 16'd1) begin
      trk_contig = seq;
      rescan_contig();
    end
    rx_map[widx(seq)] = 1'b1;
  endtask

  task automatic build_report();
    logic [15:0] s, first, scan_end;
    logic [15:0] run_first [$];
    logic [9:0]  run_len [$];
    int miss, ei;
    rltnb_pkg::out_t r;
    s = trk_contig + 16'd1;
    first = s;
    scan_end = trk_newest - 16'(trk_skip);
    miss = 0;
    while (seq_order(s, scan_end) <= 0) begin
      if (rx_map[widx(s)] || widx(s) == widx(scan_end)) begin
        if (miss != 0) begin
          run_first.push_back(first);
          run_len.push_back((miss - 1 > 1023) ? 10'd1023 : 10'(miss - 1));
          if (run_first.size() >= MAX_ENT) begin
            r = '0;
            r.status = rltnb_pkg::STATUS_FULL;
            r.report_ssrc = trk_ssrc;
            r.last_entry = 1'b1;
            expected_results.push_back(r);
            return;
          end
          miss = 0;
        end
        first = s + 16'd1;
      end else begin
        miss++;
      end
      s = s + 16'd1;
    end
    if (run_first.size() == 0) begin
      r = '0;
      r.status = rltnb_pkg::STATUS_NONE;
      r.report_ssrc = trk_ssrc;
      r.last_entry = 1'b1;
      expected_results.push_back(r);
      return;
    end
    for (ei = 0; ei < run_first.size(); ei++) begin
      r.status = rltnb_pkg::STATUS_ENTRY;
      r.run_start = run_first[ei];
      r.run_follow = run_len[ei];
      r.report_ssrc = trk_ssrc;
      r.entry_total = 5'(run_first.size());
      r.last_entry = (ei == run_first.size() - 1);
      expected_results.push_back(r);
    end
  endtask

  always @(posedge clk_i) begin
    rltnb_pkg::out_t e;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result with none expected: %p", out_data);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_data.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_data.status); errors++;
        end
        if (out_data.run_start !== e.run_start) begin
          $error("run_start: expected %0d, got %0d", e.run_start, out_data.run_start);
          errors++;
        end
        if (out_data.run_follow !== e.run_follow) begin
          $error("run_follow: expected %0d, got %0d", e.run_follow, out_data.run_follow);
          errors++;
        end
        if (out_data.report_ssrc !== e.report_ssrc) begin
          $error("report_ssrc: expected %h, got %h", e.report_ssrc, out_data.report_ssrc);
          errors++;
        end
        if (out_data.entry_total !== e.entry_total) begin
          $error("entry_total: expected %0d, got %0d", e.entry_total, out_data.entry_total);
          errors++;
        end
        if (out_data.last_entry !== e.last_entry) begin
          $error("last_entry: expected %0d, got %0d", e.last_entry, out_data.last_entry);
          errors++;
        end
      end
    end
  end

  task automatic send_item(logic op, logic [15:0] seq, logic [31:0] ssrc);
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_data <= '{operation: op, seq_num: seq, packet_ssrc: ssrc};
    do @(posedge clk_i); while (in_stall);
    if (op == rltnb_pkg::OP_PACKET) track_packet(seq, ssrc);
    else build_report();
  endtask

  task automatic send_packet(logic [15:0] seq, logic [31:0] ssrc = 32'hA5C3_0001);
    send_item(rltnb_pkg::OP_PACKET, seq, ssrc);
  endtask

  task automatic send_report();
    send_item(rltnb_pkg::OP_REPORT, 16'($urandom()), $urandom());
  endtask

  task automatic rest(int n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
    end
  endtask

  task automatic drain();
    rest(1);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_skip(logic [9:0] v);
    drain();
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk_i); while (!cfg_ready);
    trk_skip = v;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_first_packets();
    send_report();
    send_packet(16'd100, 32'h0);
    send_packet(16'd200, 32'h0);
    send_packet(16'hFFFF, 32'hFFFF_FFFF);
    send_packet(16'h0000);
    send_packet(16'h0001);
    send_packet(16'h0004);
    send_packet(16'h0004);
    send_packet(16'h0002);
    send_report();
    send_packet(16'h0003);
    send_report();
    send_packet(16'h0009);
    send_packet(16'h0007);
    send_report();
  endtask

  task automatic test_long_runs();
    send_packet(trk_newest + 16'd1024);
    send_report();
    send_packet(trk_newest + 16'd5000);
    send_report();
    send_packet(trk_newest + 16'h8000);
    send_report();
    send_packet(trk_contig + 16'd1);
    send_report();
  endtask

  task automatic test_entry_overflow();
    repeat (34) send_packet(trk_newest + 16'd2);
    send_report();
    send_packet(trk_newest + 16'd1100);
    repeat (31) send_packet(trk_newest + 16'd2);
    send_report();
  endtask

  task automatic test_skip_extremes();
    write_skip(10'd1023);
    send_packet(trk_newest + 16'd3);
    send_report();
    write_skip(10'd2);
    send_report();
    write_skip(10'd0);
    send_report();
  endtask

  task automatic test_random_traffic(int n);
    int k, r, burst;
    logic [31:0] ssrc;
    burst = $urandom_range(1, 12);
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      ssrc = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom();
      if (r < 14) send_report();
      else if (r < 70) send_packet(trk_newest + 16'($urandom_range(1, 3)), ssrc);
      else if (r < 80) send_packet(trk_newest - 16'($urandom_range(0, 40)), ssrc);
      else if (r < 88) send_packet(trk_contig + 16'd1, ssrc);
      else if (r < 93) send_packet(trk_newest, ssrc);
      else if (r < 97) send_packet(trk_newest + 16'($urandom_range(4, 300)), ssrc);
      else send_packet(16'($urandom()), ssrc);
      if (--burst == 0) begin
        rest($urandom_range(1, 8));
        burst = $urandom_range(1, 12);
      end
    end
    send_report();
  endtask

  initial begin
    int ph;
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    trk_ssrc = '0;
    trk_contig = '0;
    trk_newest = '0;
    trk_skip = '0;
    foreach (rx_map[i]) rx_map[i] = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_first_packets();
    test_long_runs();
    test_entry_overflow();
    test_skip_extremes();
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_skip(10'd0);
        1: write_skip(10'($urandom_range(1, 8)));
        2: write_skip(10'($urandom_range(0, 1023)));
        default: write_skip(10'd1023);
      endcase
      test_random_traffic(40);
    end
    drain();
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
